// ===== hdl/pfdf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfdf_pkg;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_DRAW    = 2'd0,
        OP_CLEAR   = 2'd1,
        OP_REFRESH = 2'd2
    } op_t;

    // controller command bytes
    localparam logic [7:0] CMD_PAGE_BASE = 8'hb0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
    localparam int         HEADER_LEN    = 3;

    // block control state
    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } state_t;

    // input word
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
        logic       pixel_on;
    } in_word_t;

    // output word
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       frame_end;
    } out_word_t;

    // pixel update that rides along with a store read
    typedef struct packed {
        logic       write;
        logic [2:0] bit_sel;
        logic       on;
    } draw_req_t;

    // what the feed cursor says about the current refresh byte
    typedef struct packed {
        logic       is_data;
        logic       frame_end;
        logic [7:0] cmd_byte;
    } refresh_info_t;

endpackage

`default_nettype wire

// ===== hdl/pfdf_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pfdf_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/pfdf_cursor.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfdf_cursor #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8,
    localparam int AW = $clog2(COLUMNS * PAGES),
    localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1,
    localparam int POS_W = $clog2(COLUMNS + pfdf_pkg::HEADER_LEN)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    output pfdf_pkg::refresh_info_t      info,
    output logic [AW-1:0]                data_addr
);

    localparam logic [POS_W-1:0] POS_LAST =
        POS_W'(COLUMNS + pfdf_pkg::HEADER_LEN - 1);
    localparam logic [PG_W-1:0] PAGE_LAST = PG_W'(PAGES - 1);

    logic [PG_W-1:0]  page_reg;
    logic [PG_W-1:0]  page_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] col;

    // current byte of the feed
    always_comb
    begin
        col = pos_reg - POS_W'(pfdf_pkg::HEADER_LEN);
        data_addr = AW'(32'(page_reg) * COLUMNS + 32'(col));
        info.is_data = 1'b0;
        info.frame_end = 1'b0;
        info.cmd_byte = pfdf_pkg::CMD_PAGE_BASE + 8'(page_reg);
        priority if (pos_reg == POS_W'(0))
        begin
            info.cmd_byte = pfdf_pkg::CMD_PAGE_BASE + 8'(page_reg);
        end
        else if (pos_reg == POS_W'(1))
        begin
            info.cmd_byte = pfdf_pkg::CMD_COL_LOW;
        end
        else if (pos_reg == POS_W'(2))
        begin
            info.cmd_byte = pfdf_pkg::CMD_COL_HIGH;
        end
        else
        begin
            info.is_data = 1'b1;
            info.frame_end = (pos_reg == POS_LAST) && (page_reg == PAGE_LAST);
        end
    end

    // advance position and page
    always_comb
    begin
        pos_next = pos_reg;
        page_next = page_reg;
        if (step)
        begin
            if (pos_reg == POS_LAST)
            begin
                pos_next = '0;
                page_next = (page_reg == PAGE_LAST) ? '0 : page_reg + PG_W'(1);
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            page_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            page_reg <= page_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pfdf_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfdf_store #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8,
    localparam int DEPTH = COLUMNS * PAGES,
    localparam int AW = $clog2(COLUMNS * PAGES)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                acc_en,
    input  wire logic [AW-1:0]       acc_addr,
    input  wire pfdf_pkg::draw_req_t acc_draw,
    input  wire logic                sweep_en,
    input  wire logic [AW-1:0]       sweep_addr,
    output logic [7:0]               cur_byte
);

    logic [7:0] mem [DEPTH];

    logic [7:0]          rd_data_reg;
    logic [AW-1:0]       s2_addr_reg;
    pfdf_pkg::draw_req_t draw_reg;
    pfdf_pkg::draw_req_t draw_next;
    logic                fwd_valid_reg;
    logic                fwd_valid_next;
    logic [AW-1:0]       fwd_addr_reg;
    logic [7:0]          fwd_data_reg;
    logic [7:0]          mask;
    logic [7:0]          new_byte;

    // read data with forwarding of the write made while it was read
    always_comb
    begin
        cur_byte = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                      : rd_data_reg;
        mask = 8'd1 << draw_reg.bit_sel;
        new_byte = draw_reg.on ? (cur_byte | mask) : (cur_byte & ~mask);
    end

    // pending update and forward control
    always_comb
    begin
        draw_next = '0;
        fwd_valid_next = fwd_valid_reg;
        if (acc_en)
        begin
            draw_next = acc_draw;
            fwd_valid_next = draw_reg.write;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draw_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            draw_reg <= draw_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // forward payload and item address
    always_ff @(posedge clk)
    begin
        if (acc_en)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= new_byte;
            s2_addr_reg <= acc_addr;
        end
    end

    // pixel memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (sweep_en)
        begin
            mem[sweep_addr] <= 8'h00;
        end
        else if (draw_reg.write)
        begin
            mem[s2_addr_reg] <= new_byte;
        end
        if (acc_en)
        begin
            rd_data_reg <= mem[acc_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/page_framebuffer_display_feeder_core.sv =====
// A refresh word accepted on req goes through the refresh stage register and the output
// register to rsp. Throughput: one draw or refresh word per cycle unless rsp back-pressure
// or a clear stalls req; a pixel update reads the pixel memory and writes the byte back
// the next cycle, forwarded to a read made in that cycle. A clear walks all COLUMNS*PAGES
// bytes of the pixel memory (1024 by default) one byte a cycle with req stalled. Reset
// clears control state and starts the same clearing pass; the refresh cursor resets to the page command of page 0.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_display_feeder_core #(
    parameter int COLUMNS = 128,
    parameter int PAGES = 8
) (
    input wire logic      clk,
    input wire logic      rst_n,
    pfdf_stream_if.sink   req,
    pfdf_stream_if.source rsp
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);

    pfdf_pkg::in_word_t      req_word;
    pfdf_pkg::state_t        state_reg;
    pfdf_pkg::state_t        state_next;
    logic [AW-1:0]           sweep_cnt_reg;
    logic [AW-1:0]           sweep_cnt_next;
    logic                    sweep_en;
    logic                    run;

    logic                    accept;
    logic                    s2_ok;
    logic                    ref_valid_reg;
    logic                    ref_valid_next;
    pfdf_pkg::refresh_info_t ref_info_reg;
    pfdf_pkg::refresh_info_t cur_info;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    pfdf_pkg::out_word_t     out_word_reg;

    logic                    is_draw;
    logic                    is_refresh;
    logic                    is_clear;
    logic                    on_screen;
    logic [AW-1:0]           draw_addr;
    logic [AW-1:0]           refresh_addr;
    logic [AW-1:0]           acc_addr;
    logic                    acc_en;
    pfdf_pkg::draw_req_t     acc_draw;
    logic [7:0]              cur_byte;

    assign req_word = req.payload;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfdf_pkg::ST_CLEAR:
            begin
                if (sweep_cnt_reg == SWEEP_LAST)
                begin
                    state_next = pfdf_pkg::ST_RUN;
                end
            end
            pfdf_pkg::ST_RUN:
            begin
                if (accept && is_clear)
                begin
                    state_next = pfdf_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = pfdf_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        sweep_en = 1'b0;
        run = 1'b0;
        unique case (state_reg)
            pfdf_pkg::ST_CLEAR: sweep_en = 1'b1;
            pfdf_pkg::ST_RUN:   run = 1'b1;
            default:            sweep_en = 1'b0;
        endcase
    end

    // clear address counter
    always_comb
    begin
        sweep_cnt_next = '0;
        if (sweep_en && (sweep_cnt_reg != SWEEP_LAST))
        begin
            sweep_cnt_next = sweep_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfdf_pkg::ST_CLEAR;
            sweep_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // decode of the incoming word
    always_comb
    begin
        is_draw = (req_word.operation == pfdf_pkg::OP_DRAW);
        is_clear = (req_word.operation == pfdf_pkg::OP_CLEAR);
        is_refresh = (req_word.operation == pfdf_pkg::OP_REFRESH);
        on_screen = ({1'b0, req_word.pixel_x} < 9'(COLUMNS))
                 && ({1'b0, req_word.pixel_y} < 9'(PAGES * 8));
        draw_addr = AW'(32'(req_word.pixel_y[7:3]) * COLUMNS + 32'(req_word.pixel_x));
    end

    // handshake: the refresh stage moves on when the output register has room
    assign s2_ok = !ref_valid_reg || !out_valid_reg || rsp.ready;
    assign req.ready = run && s2_ok;
    assign accept = req.valid && req.ready;

    // memory access for a draw or a refresh data byte
    always_comb
    begin
        acc_en = accept && (is_draw || is_refresh);
        acc_addr = is_draw ? draw_addr : refresh_addr;
        acc_draw.write = is_draw && on_screen;
        acc_draw.bit_sel = req_word.pixel_y[2:0];
        acc_draw.on = req_word.pixel_on;
    end

    pfdf_cursor #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (accept && is_refresh),
        .info      (cur_info),
        .data_addr (refresh_addr)
    );

    pfdf_store #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc_en     (acc_en),
        .acc_addr   (acc_addr),
        .acc_draw   (acc_draw),
        .sweep_en   (sweep_en),
        .sweep_addr (sweep_cnt_reg),
        .cur_byte   (cur_byte)
    );

    // refresh stage and output register control
    always_comb
    begin
        ref_valid_next = ref_valid_reg;
        if (accept)
        begin
            ref_valid_next = is_refresh;
        end
        else if (s2_ok)
        begin
            ref_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (ref_valid_reg && s2_ok)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ref_valid_reg <= ref_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // refresh word payload
    always_ff @(posedge clk)
    begin
        if (accept && is_refresh)
        begin
            ref_info_reg <= cur_info;
        end
        if (ref_valid_reg && s2_ok)
        begin
            out_word_reg.bus_byte <= ref_info_reg.is_data ? cur_byte : ref_info_reg.cmd_byte;
            out_word_reg.is_data <= ref_info_reg.is_data;
            out_word_reg.frame_end <= ref_info_reg.frame_end;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_word_reg;

    // a frame end word is always a data word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_word_reg.frame_end || out_word_reg.is_data))
        else $error("frame end flagged on a command word");

    // an accepted clear starts the memory sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_clear) |=> (sweep_en && (sweep_cnt_reg == '0)))
        else $error("clear did not start the sweep");

    // a stalled refresh word keeps its info and is not overtaken
    assert property (@(posedge clk) disable iff (!rst_n)
        (ref_valid_reg && !s2_ok) |=> (ref_valid_reg && $stable(ref_info_reg)))
        else $error("stalled refresh word changed");

    // no new word enters while the memory is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        sweep_en |-> !acc_en)
        else $error("memory access during clear sweep");

endmodule

`default_nettype wire

// ===== tb/sv/pfdf_tb_pkg.sv =====
`timescale 1ns / 1ps

package pfdf_tb_pkg;
    import pfdf_pkg::*;

    localparam int         FB_COLUMNS = 128;
    localparam int         FB_PAGES   = 8;
    localparam int         PIX_BYTES  = FB_COLUMNS * FB_PAGES;
    localparam int         LAST_X     = FB_COLUMNS - 1;
    localparam int         LAST_Y     = FB_PAGES * 8 - 1;
    localparam int         LAST_POS   = HEADER_LEN + FB_COLUMNS - 1;
    // operation code the block has no use for
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    class feed_scoreboard;
        // shadow picture and refresh cursor
        logic [7:0]  pixels [PIX_BYTES];
        logic [2:0]  feed_page;
        logic [7:0]  feed_pos;
        out_word_t   expected_bytes [$];

        int          mismatches;
        int          n_draw;
        int          n_off_screen;
        int          n_clear;
        int          n_refresh;
        int          n_unused;
        int          n_frame_end;

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            feed_page    = '0;
            feed_pos     = '0;
            mismatches   = 0;
            n_draw       = 0;
            n_off_screen = 0;
            n_clear      = 0;
            n_refresh    = 0;
            n_unused     = 0;
            n_frame_end  = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        // apply one accepted input word to the shadow state
        function void take_word(in_word_t w);
            logic [9:0] idx;
            logic [6:0] col;
            out_word_t  e;
            case (w.operation)
                OP_DRAW:
                begin
                    n_draw++;
                    if (w.pixel_x > LAST_X || w.pixel_y > LAST_Y)
                    begin
                        n_off_screen++;
                    end
                    else
                    begin
                        idx = {w.pixel_y[5:3], w.pixel_x[6:0]};
                        pixels[idx][w.pixel_y[2:0]] = w.pixel_on;
                    end
                end
                OP_CLEAR:
                begin
                    n_clear++;
                    foreach (pixels[i]) pixels[i] = 8'h00;
                end
                OP_REFRESH:
                begin
                    n_refresh++;
                    e = '0;
                    if (feed_pos == 8'd0)
                        e.bus_byte = CMD_PAGE_BASE + {5'd0, feed_page};
                    else if (feed_pos == 8'd1)
                        e.bus_byte = CMD_COL_LOW;
                    else if (feed_pos == 8'd2)
                        e.bus_byte = CMD_COL_HIGH;
                    else
                    begin
                        col        = 7'(feed_pos - HEADER_LEN);
                        e.bus_byte = pixels[{feed_page, col}];
                        e.is_data  = 1'b1;
                        e.frame_end = (col == 7'(LAST_X)) && (feed_page == 3'(FB_PAGES - 1));
                    end
                    // advance cursor, wrapping to the next page header
                    if (feed_pos == 8'(LAST_POS))
                    begin
                        feed_pos  = '0;
                        feed_page = feed_page + 3'd1;
                    end
                    else
                    begin
                        feed_pos = feed_pos + 8'd1;
                    end
                    expected_bytes.push_back(e);
                end
                default:
                begin
                    n_unused++;
                end
            endcase
        endfunction

        // compare one output word with the oldest expected byte
        task check_byte(out_word_t got);
            out_word_t e;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte %02h", got.bus_byte));
                return;
            end
            e = expected_bytes.pop_front();
            if (got.bus_byte !== e.bus_byte)
                report_mismatch($sformatf("bus_byte %02h, want %02h", got.bus_byte, e.bus_byte));
            if (got.is_data !== e.is_data)
                report_mismatch($sformatf("is_data %b, want %b", got.is_data, e.is_data));
            if (got.frame_end !== e.frame_end)
                report_mismatch($sformatf("frame_end %b, want %b", got.frame_end, e.frame_end));
            if (e.frame_end)
                n_frame_end++;
        endtask

        task check_leftover();
            if (expected_bytes.size() != 0)
                report_mismatch($sformatf("%0d refresh bytes never came", expected_bytes.size()));
        endtask
    endclass

endpackage

// ===== tb/sv/page_framebuffer_display_feeder_core_tb.sv =====
`timescale 1ns / 1ps

module page_framebuffer_display_feeder_core_tb;
    import pfdf_pkg::*;
    import pfdf_tb_pkg::*;

    localparam int RANDOM_ITEMS = 570;
    localparam int LONG_HOLD    = 400;
    localparam int FLOOD_ITEMS  = 60;

    logic clk = 1'b0;
    logic rst_n;

    pfdf_stream_if #(.payload_t(in_word_t))  req_if ();
    pfdf_stream_if #(.payload_t(out_word_t)) rsp_if ();

    page_framebuffer_display_feeder_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    feed_scoreboard sb = new();

    // long receiver hold-offs asked by the stimulus
    int hold_asked = 0;

    always #5 clk = ~clk;

    // safety limit
    initial
    begin
        #3_000_000;
        $display("timeout at %0t", $time);
        $display("status: fail");
        $finish;
    end

    // receiver: stall patterns chosen at random and changed after a random stretch
    initial
    begin : sink_pattern
        int mode;
        int mode_left;
        int hold_left;
        int hold_served;
        int tick;
        mode        = 0;
        mode_left   = 0;
        hold_left   = 0;
        hold_served = 0;
        tick        = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_byte(rsp_if.payload);
    end

    function automatic in_word_t mk_word(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                         logic on);
        in_word_t w;
        w.operation = op;
        w.pixel_x   = x;
        w.pixel_y   = y;
        w.pixel_on  = on;
        return w;
    endfunction

    // mostly refresh bytes, with draws aimed at the page being fed
    function automatic in_word_t random_word();
        in_word_t w;
        int       pick;
        int       aim;
        w.pixel_x  = 8'($urandom);
        w.pixel_y  = 8'($urandom);
        w.pixel_on = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            w.operation = OP_REFRESH;
        end
        else if (pick < 98)
        begin
            w.operation = OP_DRAW;
            aim = $urandom_range(0, 9);
            if (aim >= 2)
                w.pixel_x = 8'($urandom_range(0, LAST_X));
            if (aim >= 6)
                w.pixel_y = {2'b00, sb.feed_page, 3'($urandom)};
            else if (aim >= 2)
                w.pixel_y = 8'($urandom_range(0, LAST_Y));
        end
        else if (pick < 99)
        begin
            w.operation = OP_CLEAR;
        end
        else
        begin
            w.operation = OP_UNUSED;
        end
        return w;
    endfunction

    // offer one word and hold it until accepted; valid stays high afterwards
    task send_word(in_word_t w);
        req_if.valid   <= 1'b1;
        req_if.payload <= w;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        sb.take_word(w);
    endtask

    task idle_cycles(int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task wait_drained();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        int remaining;
        int burst;
        req_if.valid   <= 1'b0;
        req_if.payload <= '0;
        rst_n          <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, off-screen draws, unused code, clear mid-page
        send_word(mk_word(OP_DRAW, 8'd0, 8'd0, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd127, 8'd63, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd128, 8'd0, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd0, 8'd64, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd255, 8'd255, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd3, 8'd7, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd3, 8'd6, 1'b1));
        send_word(mk_word(OP_DRAW, 8'd3, 8'd7, 1'b0));
        send_word(mk_word(OP_UNUSED, 8'hff, 8'hff, 1'b1));
        repeat (7) send_word(mk_word(OP_REFRESH, 8'h00, 8'h00, 1'b0));
        send_word(mk_word(OP_CLEAR, 8'hff, 8'hff, 1'b1));
        repeat (3) send_word(mk_word(OP_REFRESH, 8'hff, 8'hff, 1'b1));

        // sender pauses until every refresh byte is back
        wait_drained();

        // receiver holds off while refresh words keep coming
        hold_asked = hold_asked + 1;
        repeat (FLOOD_ITEMS) send_word(mk_word(OP_REFRESH, 8'h00, 8'h00, 1'b0));
        wait_drained();

        // random part in bursts with random gaps
        remaining = RANDOM_ITEMS;
        while (remaining > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && remaining > 0)
            begin
                send_word(random_word());
                burst--;
                remaining--;
            end
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end

        wait_drained();
        repeat (20) @(posedge clk);
        sb.check_leftover();

        $display("covered %0d draws (%0d off screen), %0d clears, %0d refresh bytes",
                 sb.n_draw, sb.n_off_screen, sb.n_clear, sb.n_refresh);
        $display("frames completed %0d, unused-code words %0d, mismatches %0d",
                 sb.n_frame_end, sb.n_unused, sb.mismatches);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
